// ===== hdl/multi_motor_velocity_pid_top_macros.svh =====
// Assertion macros for the four-motor velocity controller.
// Included by the port checker; depends on nothing else.
`ifndef MULTI_MOTOR_VELOCITY_PID_TOP_MACROS_SVH
`define MULTI_MOTOR_VELOCITY_PID_TOP_MACROS_SVH

// The property is checked only while reset is low.
`define MMVP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The property is checked at every edge, reset included.
`define MMVP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/mmvp_pkg.sv =====
// Shared types and constants of the four-motor velocity controller.
// Used by the front end, the back end, the result queue and the top level.
package mmvp_pkg;

  localparam int MOTOR_COUNT = 4;
  localparam int MOTOR_W     = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [10:0]        FEEDBACK_BASE_ID = 11'h201;
  localparam logic signed [15:0] COAST_THRESHOLD  = 16'sd100;
  localparam logic signed [15:0] COAST_BRAKE      = 16'sd2000;

  typedef enum logic [2:0] {
    REQ_FEEDBACK = 3'd0,
    REQ_SPEED    = 3'd1,
    REQ_CURRENT  = 3'd2,
    REQ_ESTOP    = 3'd3,
    REQ_COAST    = 3'd4
  } req_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_KP   = 3'd0,
    CFG_KI   = 3'd1,
    CFG_KD   = 3'd2,
    CFG_ILIM = 3'd3,
    CFG_OLIM = 3'd4,
    CFG_CLIM = 3'd5,
    CFG_HOT  = 3'd6
  } cfg_index_t;

  typedef struct packed {
    req_t               op;
    logic [MOTOR_W-1:0] motor;
    logic signed [15:0] value;
    logic [7:0]         temp;
  } cmd_t;

  typedef struct packed {
    logic [MOTOR_W-1:0] motor;
    logic signed [15:0] current;
    logic               faulted;
    logic               last;
  } result_t;

endpackage

// ===== hdl/mmvp_front.sv =====
// Front end: accepts input items, drops those that have no effect, and
// queues the rest as decoded commands. Depends on mmvp_pkg.
module mmvp_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [2:0]                    req_type,
  input  logic [10:0]                   frame_id,
  input  logic [63:0]                   frame_payload,
  input  logic [1:0]                    motor_index,
  input  logic signed [15:0]            target_speed,
  input  logic signed [15:0]            current_setpoint,
  output logic                          cmd_valid,
  output mmvp_pkg::cmd_t                cmd_head,
  input  logic                          cmd_pop
);

  mmvp_pkg::cmd_t                    q [mmvp_pkg::QUEUE_DEPTH];
  logic [mmvp_pkg::QPTR_W-1:0]       wr_ptr;
  logic [mmvp_pkg::QPTR_W-1:0]       rd_ptr;
  logic [mmvp_pkg::QPTR_W:0]         count;
  mmvp_pkg::cmd_t                    entry;
  logic                              keep;
  logic [10:0]                       fb_offset;
  logic                              do_wr;
  logic                              do_rd;

  always_comb begin
    fb_offset   = frame_id - mmvp_pkg::FEEDBACK_BASE_ID;
    keep        = 1'b0;
    entry.op    = mmvp_pkg::REQ_FEEDBACK;
    entry.motor = motor_index;
    entry.value = target_speed;
    entry.temp  = frame_payload[15:8];
    unique case (req_type)
      mmvp_pkg::REQ_FEEDBACK: begin
        keep        = (frame_id >= mmvp_pkg::FEEDBACK_BASE_ID) &&
                      (fb_offset < 11'(mmvp_pkg::MOTOR_COUNT));
        entry.motor = fb_offset[mmvp_pkg::MOTOR_W-1:0];
        entry.value = frame_payload[47:32];
      end
      mmvp_pkg::REQ_SPEED: begin
        keep     = 32'(motor_index) < mmvp_pkg::MOTOR_COUNT;
        entry.op = mmvp_pkg::REQ_SPEED;
      end
      mmvp_pkg::REQ_CURRENT: begin
        keep        = 32'(motor_index) < mmvp_pkg::MOTOR_COUNT;
        entry.op    = mmvp_pkg::REQ_CURRENT;
        entry.value = current_setpoint;
      end
      mmvp_pkg::REQ_ESTOP: begin
        keep     = 1'b1;
        entry.op = mmvp_pkg::REQ_ESTOP;
      end
      mmvp_pkg::REQ_COAST: begin
        keep     = 1'b1;
        entry.op = mmvp_pkg::REQ_COAST;
      end
      default: keep = 1'b0;
    endcase
  end

  assign full      = (count == (mmvp_pkg::QPTR_W+1)'(mmvp_pkg::QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd_head  = q[rd_ptr];
  assign do_wr     = push && !full && keep;
  assign do_rd     = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (!do_wr && do_rd) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q[wr_ptr] <= entry;
    end
  end

endmodule

// ===== hdl/mmvp_back.sv =====
// Back end: holds the configuration and per-motor state, and executes queued
// commands, including the fixed-point PID. Depends on mmvp_pkg.
module mmvp_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mmvp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mmvp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                cmd_valid,
  input  mmvp_pkg::cmd_t                      cmd_head,
  output logic                                cmd_pop,
  input  logic                                res_full,
  output logic                                res_push,
  output mmvp_pkg::result_t                   res_data
);

  typedef enum logic [3:0] {
    S_FETCH, S_EXEC, S_SWEEP, S_DIFF, S_MUL, S_INT, S_SUM, S_SAT, S_OUT
  } state_t;

  state_t                            state;
  mmvp_pkg::cmd_t                    cur;
  logic [mmvp_pkg::MOTOR_W-1:0]      cnt;

  logic [15:0]                       kp;
  logic [15:0]                       ki;
  logic [15:0]                       kd;
  logic [14:0]                       ilim;
  logic [14:0]                       olim;
  logic [14:0]                       clim;
  logic [7:0]                        hot;

  logic signed [15:0]                speed_mem [mmvp_pkg::MOTOR_COUNT];
  logic                              fault_mem [mmvp_pkg::MOTOR_COUNT];
  logic signed [31:0]                integ_mem [mmvp_pkg::MOTOR_COUNT];
  logic signed [16:0]                prev_mem  [mmvp_pkg::MOTOR_COUNT];

  logic signed [16:0]                err_r;
  logic signed [17:0]                derr_r;
  logic signed [33:0]                p_r;
  logic signed [33:0]                kierr_r;
  logic signed [34:0]                d_r;
  logic signed [31:0]                integ_r;
  logic signed [44:0]                sum_r;
  logic signed [31:0]                sat_r;

  logic [mmvp_pkg::MOTOR_W-1:0]      rd_motor;
  logic signed [15:0]                speed_rd;
  logic                              fault_rd;
  logic signed [31:0]                integ_rd;
  logic signed [16:0]                prev_rd;
  logic signed [16:0]                err;
  logic signed [17:0]                derr;
  logic signed [33:0]                p_next;
  logic signed [33:0]                kierr_next;
  logic signed [34:0]                d_next;
  logic signed [34:0]                integ_sum;
  logic signed [34:0]                ilim_q;
  logic signed [31:0]                integ_new;
  logic signed [44:0]                sum_next;
  logic signed [44:0]                olim_q;
  logic signed [31:0]                sat_next;
  logic signed [15:0]                quot;
  logic signed [15:0]                pid_cur;
  logic signed [15:0]                coast_raw;
  logic signed [15:0]                sweep_cur;
  logic                              sweep_last;

  function automatic logic signed [15:0] clamp_cur(input logic signed [15:0] v,
                                                   input logic [14:0] lim);
    logic signed [15:0] hi;
    logic signed [15:0] lo;
    hi = $signed({1'b0, lim});
    lo = -hi;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  assign cfg_ready = 1'b1;

  always_comb begin
    rd_motor   = (state == S_SWEEP) ? cnt : cur.motor;
    speed_rd   = speed_mem[rd_motor];
    fault_rd   = fault_mem[rd_motor];
    integ_rd   = integ_mem[rd_motor];
    prev_rd    = prev_mem[rd_motor];

    err        = {cur.value[15], cur.value} - {speed_rd[15], speed_rd};
    derr       = {err[16], err} - {prev_rd[16], prev_rd};

    p_next     = $signed({1'b0, kp}) * err_r;
    kierr_next = $signed({1'b0, ki}) * err_r;
    d_next     = $signed({1'b0, kd}) * derr_r;

    integ_sum  = 35'(integ_rd) + 35'(kierr_r);
    ilim_q     = $signed({4'b0, ilim, 16'b0});
    if (integ_sum > ilim_q) begin
      integ_new = ilim_q[31:0];
    end else if (integ_sum < -ilim_q) begin
      integ_new = 32'(-ilim_q);
    end else begin
      integ_new = integ_sum[31:0];
    end

    sum_next   = (45'(p_r) <<< 8) + 45'(integ_r) + (45'(d_r) <<< 8);
    olim_q     = $signed({14'b0, olim, 16'b0});
    if (sum_r > olim_q) begin
      sat_next = olim_q[31:0];
    end else if (sum_r < -olim_q) begin
      sat_next = 32'(-olim_q);
    end else begin
      sat_next = sum_r[31:0];
    end

    // Division by 65536 truncates toward zero.
    quot       = sat_r[31:16] + {15'b0, (sat_r[31] && (sat_r[15:0] != 16'b0))};
    pid_cur    = clamp_cur(quot, clim);

    if (speed_rd > mmvp_pkg::COAST_THRESHOLD) begin
      coast_raw = -mmvp_pkg::COAST_BRAKE;
    end else if (speed_rd < -mmvp_pkg::COAST_THRESHOLD) begin
      coast_raw = mmvp_pkg::COAST_BRAKE;
    end else begin
      coast_raw = 16'sd0;
    end
    sweep_cur  = (cur.op == mmvp_pkg::REQ_ESTOP) ? 16'sd0 : clamp_cur(coast_raw, clim);
    sweep_last = (cnt == mmvp_pkg::MOTOR_W'(mmvp_pkg::MOTOR_COUNT - 1));

    cmd_pop          = (state == S_FETCH) && cmd_valid;
    res_push         = 1'b0;
    res_data.motor   = cur.motor;
    res_data.current = pid_cur;
    res_data.faulted = 1'b0;
    res_data.last    = 1'b1;
    unique case (state)
      S_EXEC: begin
        res_push         = (cur.op == mmvp_pkg::REQ_CURRENT) && !res_full;
        res_data.current = clamp_cur(cur.value, clim);
        res_data.faulted = fault_rd;
      end
      S_SWEEP: begin
        res_push         = !res_full;
        res_data.motor   = cnt;
        res_data.current = sweep_cur;
        res_data.faulted = fault_rd;
        res_data.last    = sweep_last;
      end
      S_OUT: begin
        res_push = !res_full;
      end
      default: res_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FETCH;
      cnt   <= '0;
      kp    <= 16'd768;
      ki    <= 16'd328;
      kd    <= 16'd512;
      ilim  <= 15'd8000;
      olim  <= 15'd16384;
      clim  <= 15'd16384;
      hot   <= 8'd100;
      for (int i = 0; i < mmvp_pkg::MOTOR_COUNT; i++) begin
        speed_mem[i] <= '0;
        fault_mem[i] <= 1'b0;
        integ_mem[i] <= '0;
        prev_mem[i]  <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          mmvp_pkg::CFG_KP:   kp   <= cfg_data;
          mmvp_pkg::CFG_KI:   ki   <= cfg_data;
          mmvp_pkg::CFG_KD:   kd   <= cfg_data;
          mmvp_pkg::CFG_ILIM: ilim <= cfg_data[14:0];
          mmvp_pkg::CFG_OLIM: olim <= cfg_data[14:0];
          mmvp_pkg::CFG_CLIM: clim <= cfg_data[14:0];
          mmvp_pkg::CFG_HOT:  hot  <= cfg_data[7:0];
          default: ;
        endcase
      end

      unique case (state)
        S_FETCH: begin
          if (cmd_valid) begin
            cur <= cmd_head;
            cnt <= '0;
            unique case (cmd_head.op) inside
              mmvp_pkg::REQ_ESTOP, mmvp_pkg::REQ_COAST: state <= S_SWEEP;
              mmvp_pkg::REQ_SPEED:                      state <= S_DIFF;
              default:                                  state <= S_EXEC;
            endcase
          end
        end
        S_EXEC: begin
          if (cur.op == mmvp_pkg::REQ_FEEDBACK) begin
            speed_mem[cur.motor] <= cur.value;
            fault_mem[cur.motor] <= (cur.temp > hot);
            state                <= S_FETCH;
          end else if (res_push) begin
            state <= S_FETCH;
          end
        end
        S_SWEEP: begin
          if (res_push) begin
            integ_mem[cnt] <= '0;
            if (cur.op == mmvp_pkg::REQ_ESTOP) begin
              prev_mem[cnt] <= '0;
            end
            cnt <= cnt + 1'b1;
            if (sweep_last) begin
              state <= S_FETCH;
            end
          end
        end
        S_DIFF: begin
          if (fault_rd) begin
            state <= S_FETCH;
          end else begin
            err_r  <= err;
            derr_r <= derr;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          p_r     <= p_next;
          kierr_r <= kierr_next;
          d_r     <= d_next;
          state   <= S_INT;
        end
        S_INT: begin
          integ_mem[cur.motor] <= integ_new;
          prev_mem[cur.motor]  <= err_r;
          integ_r              <= integ_new;
          state                <= S_SUM;
        end
        S_SUM: begin
          sum_r <= sum_next;
          state <= S_SAT;
        end
        S_SAT: begin
          sat_r <= sat_next;
          state <= S_OUT;
        end
        S_OUT: begin
          if (res_push) begin
            state <= S_FETCH;
          end
        end
        default: state <= S_FETCH;
      endcase
    end
  end

endmodule

// ===== hdl/mmvp_out_queue.sv =====
// Result queue between the back end and the result ports.
// Depends on mmvp_pkg.
module mmvp_out_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          res_push,
  input  mmvp_pkg::result_t             res_data,
  output logic                          res_full,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    out_motor,
  output logic signed [15:0]            current_command,
  output logic                          motor_faulted,
  output logic                          last_of_run
);

  mmvp_pkg::result_t                 q [mmvp_pkg::QUEUE_DEPTH];
  logic [mmvp_pkg::QPTR_W-1:0]       wr_ptr;
  logic [mmvp_pkg::QPTR_W-1:0]       rd_ptr;
  logic [mmvp_pkg::QPTR_W:0]         count;
  logic                              do_wr;
  logic                              do_rd;

  assign res_full        = (count == (mmvp_pkg::QPTR_W+1)'(mmvp_pkg::QUEUE_DEPTH));
  assign empty           = (count == '0);
  assign do_wr           = res_push && !res_full;
  assign do_rd           = pop && !empty;
  assign out_motor       = q[rd_ptr].motor;
  assign current_command = q[rd_ptr].current;
  assign motor_faulted   = q[rd_ptr].faulted;
  assign last_of_run     = q[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (!do_wr && do_rd) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q[wr_ptr] <= res_data;
    end
  end

endmodule

// ===== hdl/multi_motor_velocity_pid_top.sv =====
// Top level of the four-motor velocity controller.
// Depends on mmvp_pkg, mmvp_front, mmvp_back and mmvp_out_queue.
//
// The input side takes one item per cycle into a four-entry command queue
// while it is not full, and results leave through a four-entry result
// queue, so both sides stall on their own. The back end handles a feedback
// frame or current command in its execute state, an emergency or coast
// stop in a sweep (one result per motor per cycle while the result queue
// is not full), a speed command to a faulted motor in the difference state
// alone, and any other speed command through the PID sequencer's difference,
// multiply, integrate, sum, saturate and output stages. Configuration writes
// are taken in any cycle, and no clearing pass follows reset.
module multi_motor_velocity_pid_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [2:0]                          req_type,
  input  logic [10:0]                         frame_id,
  input  logic [63:0]                         frame_payload,
  input  logic [1:0]                          motor_index,
  input  logic signed [15:0]                  target_speed,
  input  logic signed [15:0]                  current_setpoint,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mmvp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mmvp_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                empty,
  input  logic                                pop,
  output logic [1:0]                          out_motor,
  output logic signed [15:0]                  current_command,
  output logic                                motor_faulted,
  output logic                                last_of_run
);

  logic                 cmd_valid;
  mmvp_pkg::cmd_t       cmd_head;
  logic                 cmd_pop;
  logic                 res_full;
  logic                 res_push;
  mmvp_pkg::result_t    res_data;

  mmvp_front u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .req_type         (req_type),
    .frame_id         (frame_id),
    .frame_payload    (frame_payload),
    .motor_index      (motor_index),
    .target_speed     (target_speed),
    .current_setpoint (current_setpoint),
    .cmd_valid        (cmd_valid),
    .cmd_head         (cmd_head),
    .cmd_pop          (cmd_pop)
  );

  mmvp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  mmvp_out_queue u_out_queue (
    .clk             (clk),
    .rst             (rst),
    .res_push        (res_push),
    .res_data        (res_data),
    .res_full        (res_full),
    .empty           (empty),
    .pop             (pop),
    .out_motor       (out_motor),
    .current_command (current_command),
    .motor_faulted   (motor_faulted),
    .last_of_run     (last_of_run)
  );

endmodule

// ===== hdl/mmvp_port_checker.sv =====
// Port-level checks of the four-motor velocity controller, bound to the top.
// Depends on multi_motor_velocity_pid_top_macros.svh.
`include "multi_motor_velocity_pid_top_macros.svh"

module mmvp_port_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               cfg_ready,
  input logic               empty,
  input logic               pop,
  input logic [1:0]         out_motor,
  input logic signed [15:0] current_command,
  input logic               last_of_run
);

  `MMVP_ASSERT_ALWAYS(a_cfg_ready, clk, cfg_ready, "Configuration port refused a transfer.")
  `MMVP_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> empty && !full, "Queues not cleared by reset.")
  `MMVP_ASSERT(a_result_holds, clk, rst, !empty && !pop |=> !empty && $stable(current_command) && $stable(out_motor) && $stable(last_of_run), "Waiting result changed.")
  `MMVP_ASSERT(a_run_continues, clk, rst, pop && !empty && !last_of_run |=> !empty, "Run of results broken.")

endmodule

bind multi_motor_velocity_pid_top mmvp_port_checker u_port_checker (
  .clk             (clk),
  .rst             (rst),
  .full            (full),
  .cfg_ready       (cfg_ready),
  .empty           (empty),
  .pop             (pop),
  .out_motor       (out_motor),
  .current_command (current_command),
  .last_of_run     (last_of_run)
);
